// File: design/tfn_pkg.sv
package tfn_pkg;

    // Field widths of the pixel and result requests.
    localparam int PIX_W = 16;
    localparam int LVL_W = 8;
    localparam int POS_W = 14;
    localparam int DIM_W = 8;

    // Width of the scaled numerator (clamped difference times full scale).
    localparam int NUM_W = PIX_W + LVL_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd3;

    // Register values after reset.
    localparam logic [PIX_W-1:0] LOW_LIMIT_RESET    = 16'd29315;
    localparam logic [PIX_W-1:0] HIGH_LIMIT_RESET   = 16'd31315;
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 8'd80;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 8'd60;

    // Full-scale output level.
    localparam logic [LVL_W-1:0] LEVEL_MAX = 8'd255;

    // Default frame size limits.
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 2;

    // One pending pixel: division operands plus the frame statistics.
    typedef struct packed {
        logic [NUM_W-1:0] numer;
        logic [PIX_W-1:0] denom;
        logic             frame_done;
        logic [PIX_W-1:0] max_value;
        logic [POS_W-1:0] max_position;
        logic [PIX_W-1:0] min_value;
        logic [POS_W-1:0] min_position;
        logic [PIX_W-1:0] center_value;
    } work_t;

endpackage

// File: design/tfn_pixel_if.sv
interface tfn_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [tfn_pkg::PIX_W-1:0] pixel_sample;

    modport source (output valid, output pixel_sample, input ready);
    modport sink (input valid, input pixel_sample, output ready);
endinterface

// File: design/tfn_level_if.sv
interface tfn_level_if;
    logic                      valid;
    logic                      ready;
    logic [tfn_pkg::LVL_W-1:0] pixel_level;
    logic                      frame_done;
    logic [tfn_pkg::PIX_W-1:0] max_value;
    logic [tfn_pkg::POS_W-1:0] max_position;
    logic [tfn_pkg::PIX_W-1:0] min_value;
    logic [tfn_pkg::POS_W-1:0] min_position;
    logic [tfn_pkg::PIX_W-1:0] center_value;

    modport source (
        output valid, output pixel_level, output frame_done,
        output max_value, output max_position,
        output min_value, output min_position, output center_value,
        input ready
    );
    modport sink (
        input valid, input pixel_level, input frame_done,
        input max_value, input max_position,
        input min_value, input min_position, input center_value,
        output ready
    );
endinterface

// File: design/tfn_front.sv
module tfn_front #(
    parameter int MAX_WIDTH  = tfn_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tfn_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tfn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfn_pkg::CFG_DATA_W-1:0] cfg_data,
    tfn_pixel_if.sink                     pixel,
    output logic                          push,
    output tfn_pkg::work_t                push_data,
    input  logic                          full
);
    import tfn_pkg::*;

    // The width register is 8 bits, so the usable size never exceeds 255.
    localparam int W_LIM   = (MAX_WIDTH < 255) ? MAX_WIDTH : 255;
    localparam int H_LIM   = (MAX_HEIGHT < 255) ? MAX_HEIGHT : 255;
    localparam int TOT_MAX = W_LIM * H_LIM;
    localparam int CNT_W   = (TOT_MAX > 1) ? $clog2(TOT_MAX) : 1;
    localparam int TOT_W   = $clog2(TOT_MAX + 1);
    localparam int CEN_W   = TOT_W + 1;

    localparam logic [DIM_W-1:0] W_LIM_V = DIM_W'(W_LIM);
    localparam logic [DIM_W-1:0] H_LIM_V = DIM_W'(H_LIM);
    localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);

    logic [PIX_W-1:0] low_limit_reg;
    logic [PIX_W-1:0] high_limit_reg;
    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;

    logic [CNT_W-1:0] cnt_reg,      cnt_next;
    logic [PIX_W-1:0] max_val_reg,  max_val_next;
    logic [CNT_W-1:0] max_pos_reg,  max_pos_next;
    logic [PIX_W-1:0] min_val_reg,  min_val_next;
    logic [CNT_W-1:0] min_pos_reg,  min_pos_next;
    logic             min_ok_reg;
    logic [PIX_W-1:0] center_reg,   center_next;

    logic [DIM_W-1:0] w_sat;
    logic [DIM_W-1:0] h_sat;
    logic [15:0]      prod;
    logic [TOT_W-1:0] total;
    logic [CEN_W-1:0] center_raw;
    logic [CEN_W-1:0] center_idx;
    logic             last;
    logic             accept;
    logic [PIX_W-1:0] t;
    logic [PIX_W-1:0] t_clamp;
    logic [PIX_W-1:0] span;

    assign t            = pixel.pixel_sample;
    assign pixel.ready  = !full;
    assign accept       = pixel.valid && !full;
    assign push         = accept;

    // Frame geometry from the current register values.
    always_comb
    begin
        w_sat = frame_width_reg;
        if (frame_width_reg == '0)
        begin
            w_sat = DIM_ONE;
        end
        else if (frame_width_reg > W_LIM_V)
        begin
            w_sat = W_LIM_V;
        end
        h_sat = frame_height_reg;
        if (frame_height_reg == '0)
        begin
            h_sat = DIM_ONE;
        end
        else if (frame_height_reg > H_LIM_V)
        begin
            h_sat = H_LIM_V;
        end
        prod       = 16'(w_sat) * 16'(h_sat);
        total      = TOT_W'(prod);
        center_raw = CEN_W'(total >> 1) + CEN_W'(w_sat >> 1);
        if (center_raw >= CEN_W'(total))
        begin
            center_idx = CEN_W'(total - TOT_W'(1));
        end
        else
        begin
            center_idx = center_raw;
        end
        last = TOT_W'(cnt_reg) >= (total - TOT_W'(1));
    end

    // Tracker updates including the current pixel.
    always_comb
    begin
        max_val_next = max_val_reg;
        max_pos_next = max_pos_reg;
        if (t > max_val_reg)
        begin
            max_val_next = t;
            max_pos_next = cnt_reg;
        end
        min_val_next = min_val_reg;
        min_pos_next = min_pos_reg;
        if (!min_ok_reg || (t < min_val_reg))
        begin
            min_val_next = t;
            min_pos_next = cnt_reg;
        end
        center_next = center_reg;
        if (CEN_W'(cnt_reg) == center_idx)
        begin
            center_next = t;
        end
        cnt_next = last ? '0 : cnt_reg + CNT_W'(1);
    end

    // Division operands; an empty clamp range divides zero by one.
    always_comb
    begin
        t_clamp = t;
        if (t < low_limit_reg)
        begin
            t_clamp = low_limit_reg;
        end
        else if (t > high_limit_reg)
        begin
            t_clamp = high_limit_reg;
        end
        span = high_limit_reg - low_limit_reg;

        push_data = '0;
        if (high_limit_reg > low_limit_reg)
        begin
            push_data.numer = NUM_W'(t_clamp - low_limit_reg) * NUM_W'(LEVEL_MAX);
            push_data.denom = span;
        end
        else
        begin
            push_data.numer = '0;
            push_data.denom = PIX_W'(1);
        end
        if (last)
        begin
            push_data.frame_done   = 1'b1;
            push_data.max_value    = max_val_next;
            push_data.max_position = POS_W'(max_pos_next);
            push_data.min_value    = min_val_next;
            push_data.min_position = POS_W'(min_pos_next);
            push_data.center_value = center_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_limit_reg    <= LOW_LIMIT_RESET;
            high_limit_reg   <= HIGH_LIMIT_RESET;
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOW_LIMIT:    low_limit_reg    <= PIX_W'(cfg_data);
                CFG_HIGH_LIMIT:   high_limit_reg   <= PIX_W'(cfg_data);
                CFG_FRAME_WIDTH:  frame_width_reg  <= DIM_W'(cfg_data);
                CFG_FRAME_HEIGHT: frame_height_reg <= DIM_W'(cfg_data);
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            max_val_reg <= '0;
            max_pos_reg <= '0;
            min_val_reg <= '0;
            min_pos_reg <= '0;
            min_ok_reg  <= 1'b0;
            center_reg  <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                cnt_reg     <= '0;
                max_val_reg <= '0;
                max_pos_reg <= '0;
                min_val_reg <= '0;
                min_pos_reg <= '0;
                min_ok_reg  <= 1'b0;
                center_reg  <= '0;
            end
            else
            begin
                cnt_reg     <= cnt_next;
                max_val_reg <= max_val_next;
                max_pos_reg <= max_pos_next;
                min_val_reg <= min_val_next;
                min_pos_reg <= min_pos_next;
                min_ok_reg  <= 1'b1;
                center_reg  <= center_next;
            end
        end
    end

endmodule

// File: design/tfn_queue.sv
module tfn_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tfn_pkg::work_t push_data,
    output logic           full,
    input  logic           pop,
    output tfn_pkg::work_t pop_data,
    output logic           empty
);
    import tfn_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Slot zero is always the head; entries move one slot forward on a pop.
    work_t            slot_reg  [QUEUE_DEPTH];
    work_t            slot_next [QUEUE_DEPTH];
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [CNT_W-1:0] fill_pos;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[0];

    always_comb
    begin
        // A pushed entry lands right behind the last entry that stays.
        fill_pos = do_pop ? count_reg - CNT_W'(1) : count_reg;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        if (do_pop)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                slot_next[i] = slot_reg[i + 1];
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (do_push && (fill_pos == CNT_W'(i)))
            begin
                slot_next[i] = push_data;
            end
        end
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

endmodule

// File: design/tfn_back.sv
module tfn_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  tfn_pkg::work_t pop_data,
    output logic           pop,
    tfn_level_if.source    level
);
    import tfn_pkg::*;

    localparam int STEP_W = $clog2(LVL_W);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_LOAD   = 3'b100
    } state_t;

    state_t            state_reg,  state_next;
    logic [STEP_W-1:0] step_reg,   step_next;
    logic [NUM_W-1:0]  rem_reg,    rem_next;
    logic [NUM_W-1:0]  dsh_reg,    dsh_next;
    logic [LVL_W-1:0]  quo_reg,    quo_next;
    work_t             hold_reg,   hold_next;
    logic              out_valid_reg, out_valid_next;
    logic              load_out;

    logic [LVL_W-1:0]  lvl_reg;
    logic              done_reg;
    logic [PIX_W-1:0]  max_val_reg;
    logic [POS_W-1:0]  max_pos_reg;
    logic [PIX_W-1:0]  min_val_reg;
    logic [POS_W-1:0]  min_pos_reg;
    logic [PIX_W-1:0]  center_reg;

    // Restoring divider: one quotient bit per cycle, most significant first.
    // The quotient never exceeds full scale, so LVL_W steps are enough.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        hold_next      = hold_reg;
        pop            = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && level.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    hold_next  = pop_data;
                    rem_next   = pop_data.numer;
                    dsh_next   = NUM_W'(pop_data.denom) << (LVL_W - 1);
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    quo_next = {quo_reg[LVL_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[LVL_W-2:0], 1'b0};
                end
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(LVL_W - 1))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || level.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
        hold_reg <= hold_next;
        if (load_out)
        begin
            lvl_reg     <= quo_reg;
            done_reg    <= hold_reg.frame_done;
            max_val_reg <= hold_reg.max_value;
            max_pos_reg <= hold_reg.max_position;
            min_val_reg <= hold_reg.min_value;
            min_pos_reg <= hold_reg.min_position;
            center_reg  <= hold_reg.center_value;
        end
    end

    assign level.valid        = out_valid_reg;
    assign level.pixel_level  = lvl_reg;
    assign level.frame_done   = done_reg;
    assign level.max_value    = max_val_reg;
    assign level.max_position = max_pos_reg;
    assign level.min_value    = min_val_reg;
    assign level.min_position = min_pos_reg;
    assign level.center_value = center_reg;

endmodule

// File: design/thermal_frame_normalize_minmax_top.sv
// A pixel accepted at the input reaches the output through the queue write, the pop,
// 8 divide steps and the output load, when the output side is ready.
// The bit-serial divider in the back part finishes one pixel before it pops the next.
// The input stays ready while the two-entry queue has room, so up to three pixels
// can be held inside while a finished result waits on the output.
// Reset (rst_n, asynchronous, active low) restores the register defaults and clears
// the frame trackers and all handshake state; no clearing pass is needed.
module thermal_frame_normalize_minmax_top #(
    parameter int MAX_WIDTH  = tfn_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tfn_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tfn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfn_pkg::CFG_DATA_W-1:0] cfg_data,
    tfn_pixel_if.sink                      pixel,
    tfn_level_if.source                    result
);
    import tfn_pkg::*;

    // The front part holds the configuration registers, clamps each pixel,
    // forms the operands of the scaling division and keeps the per-frame
    // maximum, minimum and center trackers. Every accepted request is
    // pushed into the queue in the same cycle.
    logic  push;
    logic  full;
    work_t push_data;

    // The back part pops one request at a time, runs the division and
    // presents the result in its output register.
    logic  pop;
    logic  empty;
    work_t pop_data;

    tfn_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // The queue decouples the two parts so that either can stall alone.
    tfn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    tfn_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .level    (result)
    );

endmodule
